// File: src/mlsh_pkg.sv
// Shared types, constants and tables for the multi-lane SHA-256 hasher.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package mlsh_pkg;

	// Lane and memory geometry.
	localparam int LANE_COUNT = 8;
	localparam int LANE_W     = 3;
	localparam int ADDR_W     = LANE_W + 3;
	localparam int RAM_DEPTH  = LANE_COUNT * 8;

	// Block assembly modes used while the schedule window is loaded.
	localparam logic [1:0] MODE_DATA = 2'd0;
	localparam logic [1:0] MODE_PAD1 = 2'd1;
	localparam logic [1:0] MODE_PADX = 2'd2;
	localparam logic [1:0] MODE_PAD2 = 2'd3;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       commit;
		logic       rd_en;
		logic [2:0] rd_idx;
		logic       init_v;
		logic       round_en;
		logic [5:0] round_idx;
		logic       fold;
		logic       wb_en;
		logic [2:0] wb_idx;
		logic       emit_load;
		logic [1:0] part;
		logic       lane_reset;
		logic [1:0] mode;
		logic [2:0] p;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       in_range;
		logic       valid8;
		logic       last;
		logic [2:0] pos;
		logic       out_free;
	} stat_t;

	// Initial hash values.
	function automatic logic [31:0] init_h(input logic [2:0] i);
		case (i)
			3'd0:    init_h = 32'h6a09e667;
			3'd1:    init_h = 32'hbb67ae85;
			3'd2:    init_h = 32'h3c6ef372;
			3'd3:    init_h = 32'ha54ff53a;
			3'd4:    init_h = 32'h510e527f;
			3'd5:    init_h = 32'h9b05688c;
			3'd6:    init_h = 32'h1f83d9ab;
			default: init_h = 32'h5be0cd19;
		endcase
	endfunction

	// Round constants.
	function automatic logic [31:0] round_k(input logic [5:0] i);
		case (i)
			6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
			6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
			6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
			6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
			6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
			6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
			6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
			6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
			6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
			6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
			6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
			6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
			6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
			6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
			6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
			6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
			6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
			6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
			6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
			6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
			6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
			6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
			6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
			6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
			6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
			6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
			6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
			6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
			6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
			6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
			6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
			6'd62: round_k = 32'hbef9a3f7;  default: round_k = 32'hc67178f2;
		endcase
	endfunction

endpackage
`default_nettype wire

// File: src/mlsh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package dependency.
`default_nettype none
module mlsh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: src/mlsh_ctrl.sv
// Controller state machine of the multi-lane SHA-256 hasher.
// Depends on mlsh_pkg for the command and status structs and mode codes.
`default_nettype none
module mlsh_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire mlsh_pkg::stat_t st,
	output mlsh_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECIDE = 3'd1;
	localparam logic [2:0] ST_LOAD   = 3'd2;
	localparam logic [2:0] ST_ROUND  = 3'd3;
	localparam logic [2:0] ST_FOLD   = 3'd4;
	localparam logic [2:0] ST_WB     = 3'd5;
	localparam logic [2:0] ST_EMIT   = 3'd6;

	logic [2:0] state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic [1:0] mode_q, mode_d;
	logic [2:0] p_q, p_d;

	assign in_ready = (state_q == ST_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		mode_d  = mode_q;
		p_d     = p_q;
		cmd     = '0;
		cmd.mode = mode_q;
		cmd.p    = p_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cnt_d = '0;
				if (!st.in_range) begin
					state_d = ST_IDLE;
				end else begin
					cmd.commit = 1'b1;
					state_d    = ST_LOAD;
					if (st.valid8) begin
						if (st.pos == 3'd7) begin
							mode_d = mlsh_pkg::MODE_DATA;
						end else if (!st.last) begin
							state_d = ST_IDLE;
						end else if (st.pos == 3'd6) begin
							mode_d = mlsh_pkg::MODE_PADX;
						end else begin
							mode_d = mlsh_pkg::MODE_PAD1;
							p_d    = st.pos + 3'd1;
						end
					end else if (st.pos == 3'd7) begin
						mode_d = mlsh_pkg::MODE_PADX;
					end else begin
						mode_d = mlsh_pkg::MODE_PAD1;
						p_d    = st.pos;
					end
				end
			end
			ST_LOAD: begin
				cmd.rd_en  = (cnt_q < 6'd8);
				cmd.rd_idx = cnt_q[2:0];
				cnt_d      = cnt_q + 6'd1;
				if (cnt_q == 6'd9) begin
					cmd.init_v = 1'b1;
					cnt_d      = '0;
					state_d    = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_en  = 1'b1;
				cmd.round_idx = cnt_q;
				cnt_d         = cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				cnt_d    = '0;
				state_d  = ST_WB;
			end
			ST_WB: begin
				cmd.wb_en  = 1'b1;
				cmd.wb_idx = cnt_q[2:0];
				cnt_d      = cnt_q + 6'd1;
				if (cnt_q == 6'd7) begin
					cnt_d = '0;
					case (mode_q)
						mlsh_pkg::MODE_DATA: begin
							if (st.last) begin
								mode_d  = mlsh_pkg::MODE_PAD1;
								p_d     = 3'd0;
								state_d = ST_LOAD;
							end else begin
								state_d = ST_IDLE;
							end
						end
						mlsh_pkg::MODE_PADX: begin
							mode_d  = mlsh_pkg::MODE_PAD2;
							state_d = ST_LOAD;
						end
						default: begin
							state_d = ST_EMIT;
						end
					endcase
				end
			end
			ST_EMIT: begin
				cmd.part = cnt_q[1:0];
				if (st.out_free) begin
					cmd.emit_load = 1'b1;
					cnt_d         = cnt_q + 6'd1;
					if (cnt_q[1:0] == 2'd3) begin
						cmd.lane_reset = 1'b1;
						state_d        = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			mode_q  <= mlsh_pkg::MODE_DATA;
			p_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			mode_q  <= mode_d;
			p_q     <= p_d;
		end
	end

endmodule
`default_nettype wire

// File: src/mlsh_dp.sv
// Datapath of the multi-lane SHA-256 hasher: lane state, block and chaining
// memories, schedule window, round unit and output word register.
// Depends on mlsh_pkg and mlsh_ram.
`default_nettype none
module mlsh_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mlsh_pkg::cmd_t cmd,
	output mlsh_pkg::stat_t     st,
	input  wire logic [71:0]    in_data,
	input  wire logic [2:0]     in_user,
	input  wire logic           in_last,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [71:0]         out_data,
	output logic [2:0]          out_user,
	output logic                out_last
);

	function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
		rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
	endfunction

	// Accepted item.
	logic [mlsh_pkg::LANE_W-1:0] lane_q;
	logic [3:0]                  valid_q;
	logic                        last_q;
	logic [63:0]                 word_q;
	logic [63:0]                 term_q;
	logic [63:0]                 len_word_q;

	// Per-lane state.
	logic [60:0] len_q   [mlsh_pkg::LANE_COUNT];
	logic [2:0]  fill_q  [mlsh_pkg::LANE_COUNT];
	logic        fresh_q [mlsh_pkg::LANE_COUNT];

	// Compression state.
	logic [31:0] w_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic        cap_v_q;
	logic [2:0]  cap_idx_q;

	logic [63:0] buf_rd;
	logic [31:0] chain_rd;
	logic [3:0]  vin_sat;
	logic [63:0] mask_in;
	logic [63:0] word_in;
	logic [63:0] term_in;
	logic [60:0] len_new;
	logic [2:0]  pos;
	logic [63:0] load_word;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;

	// Word assembly for the incoming item.
	always_comb begin
		vin_sat = (in_data[67:64] > 4'd8) ? 4'd8 : in_data[67:64];
		mask_in = ~64'd0 << (7'd64 - {vin_sat, 3'b000});
		word_in = in_data[63:0] & mask_in;
		if (vin_sat == 4'd8) begin
			term_in = 64'h80 << 56;
		end else begin
			term_in = word_in | (64'h80 << (6'd56 - {vin_sat[2:0], 3'b000}));
		end
	end

	assign pos     = fill_q[lane_q];
	assign len_new = len_q[lane_q] + {57'd0, valid_q};

	assign st.in_range = ({1'b0, lane_q} < (mlsh_pkg::LANE_W + 1)'(mlsh_pkg::LANE_COUNT));
	assign st.valid8   = (valid_q == 4'd8);
	assign st.last     = last_q;
	assign st.pos      = pos;
	assign st.out_free = !out_valid || out_ready;

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lane_q  <= in_user;
			valid_q <= vin_sat;
			last_q  <= in_last || (vin_sat != 4'd8);
			word_q  <= word_in;
			term_q  <= term_in;
		end
		if (cmd.commit) begin
			len_word_q <= {len_new, 3'b000};
		end
	end

	// Byte count, fill level and fresh-chain marks per lane.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mlsh_pkg::LANE_COUNT; i++) begin
				len_q[i]   <= '0;
				fill_q[i]  <= '0;
				fresh_q[i] <= 1'b1;
			end
		end else begin
			if (cmd.commit) begin
				if (last_q) begin
					len_q[lane_q]  <= '0;
					fill_q[lane_q] <= '0;
				end else begin
					len_q[lane_q]  <= len_new;
					fill_q[lane_q] <= pos + 3'd1;
				end
			end
			if (cmd.wb_en && cmd.wb_idx == 3'd7) begin
				fresh_q[lane_q] <= 1'b0;
			end
			if (cmd.lane_reset) begin
				fresh_q[lane_q] <= 1'b1;
			end
		end
	end

	// Block buffer and chaining memories.
	mlsh_ram #(.WIDTH(64), .DEPTH(mlsh_pkg::RAM_DEPTH)) u_buf (
		.clk   (clk),
		.we    (cmd.commit && st.valid8),
		.waddr ({lane_q, pos}),
		.wdata (word_q),
		.raddr ({lane_q, cmd.rd_idx}),
		.rdata (buf_rd)
	);

	mlsh_ram #(.WIDTH(32), .DEPTH(mlsh_pkg::RAM_DEPTH)) u_chain (
		.clk   (clk),
		.we    (cmd.wb_en),
		.waddr ({lane_q, cmd.wb_idx}),
		.wdata (h_q[cmd.wb_idx]),
		.raddr ({lane_q, cmd.rd_idx}),
		.rdata (chain_rd)
	);

	// Read data arrives in the cycle after its address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_v_q <= 1'b0;
		end else begin
			cap_v_q <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			cap_idx_q <= cmd.rd_idx;
		end
	end

	// Block word selection with padding inserted.
	always_comb begin
		load_word = 64'd0;
		case (cmd.mode)
			mlsh_pkg::MODE_DATA: begin
				load_word = buf_rd;
			end
			mlsh_pkg::MODE_PAD1: begin
				if (cap_idx_q < cmd.p) begin
					load_word = buf_rd;
				end else if (cap_idx_q == cmd.p) begin
					load_word = term_q;
				end else if (cap_idx_q == 3'd7) begin
					load_word = len_word_q;
				end
			end
			mlsh_pkg::MODE_PADX: begin
				load_word = (cap_idx_q == 3'd7) ? term_q : buf_rd;
			end
			default: begin
				load_word = (cap_idx_q == 3'd7) ? len_word_q : 64'd0;
			end
		endcase
	end

	// Message schedule and round logic.
	always_comb begin
		w_new = w_q[0]
			+ (rotr(w_q[1], 5'd7) ^ rotr(w_q[1], 5'd18) ^ (w_q[1] >> 3))
			+ w_q[9]
			+ (rotr(w_q[14], 5'd17) ^ rotr(w_q[14], 5'd19) ^ (w_q[14] >> 10));
		t1 = v_q[7]
			+ (rotr(v_q[4], 5'd6) ^ rotr(v_q[4], 5'd11) ^ rotr(v_q[4], 5'd25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ mlsh_pkg::round_k(cmd.round_idx) + w_q[0];
		t2 = (rotr(v_q[0], 5'd2) ^ rotr(v_q[0], 5'd13) ^ rotr(v_q[0], 5'd22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	always_ff @(posedge clk) begin
		if (cap_v_q) begin
			for (int i = 0; i < 14; i++) begin
				w_q[i] <= w_q[i + 2];
			end
			w_q[14] <= load_word[63:32];
			w_q[15] <= load_word[31:0];
			h_q[cap_idx_q] <= fresh_q[lane_q] ? mlsh_pkg::init_h(cap_idx_q) : chain_rd;
		end
		if (cmd.init_v) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end
		if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (cmd.fold) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_data <= {6'd0, cmd.part, h_q[{cmd.part, 1'b0}], h_q[{cmd.part, 1'b1}]};
			out_user <= lane_q;
			out_last <= (cmd.part == 2'd3);
		end
	end

endmodule
`default_nettype wire

// File: src/multi_lane_sha256_hasher.sv
// Multi-lane SHA-256 hasher: per-lane message words in, digest words out.
// Each block passes through load, 64 rounds, a fold and write-back of the eight
// hash words in the single round unit, and no new word is taken while a block
// is processed; a closing word adds one or two blocks and then the four digest
// words.
// Reset (arst_n low, asynchronous) returns every lane to the initial hash values.
`default_nettype none
module multi_lane_sha256_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,  // message_bytes[63:0], valid_bytes[67:64], zero
	input  wire logic [2:0]  s_tuser,  // lane[2:0]
	input  wire logic        s_tlast,  // end_of_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,  // digest_part[63:0], part_index[65:64], zero
	output logic [2:0]       m_tuser,  // result_lane[2:0]
	output logic             m_tlast   // last_part
);

	mlsh_pkg::cmd_t  cmd;
	mlsh_pkg::stat_t st;

	mlsh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	mlsh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.in_data   (s_tdata),
		.in_user   (s_tuser),
		.in_last   (s_tlast),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_user  (m_tuser),
		.out_last  (m_tlast)
	);

	// An accepted word always moves the controller out of the idle state into the decision state.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still ready after accepting a word");

	// The fourth digest word carries the last mark.
	a_last_part: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[65:64] == 2'd3) |-> m_tlast)
		else $error("final digest word without last mark");

	// Digest words follow one another without a gap.
	a_parts_dense: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a digest");

endmodule
`default_nettype wire
